@@ src/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg: shared definitions for the bounded double-ended queue
// Operation codes, fault codes and the fixed widths of the port fields.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Fixed widths of the port fields.
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int FAULT_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd4;
  localparam logic [OP_W-1:0] OP_COUNT      = 3'd5;

  // Fault codes.
  localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_UNDERFLOW = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OVERFLOW  = 2'd2;

endpackage

@@ src/bdq_ring_ram.sv @@
// ----------------------------------------------------------------------------
// bdq_ring_ram: ring-addressed entry store
// One write port and one registered read port. Both ports are addressed by a
// position relative to the ring base, which is mapped to a physical slot here.
// ----------------------------------------------------------------------------
module bdq_ring_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic [$clog2(DEPTH)-1:0]  base,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_pos,
  output logic [DATA_WIDTH-1:0]     rd_data,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_pos,
  input  logic [DATA_WIDTH-1:0]     wr_data
);

  localparam int PW = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]         rd_slot;
  logic [PW-1:0]         wr_slot;

  // Physical slot is (base + pos) modulo DEPTH; both are below DEPTH, so one
  // conditional subtract is enough.
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] b, input logic [PW-1:0] p);
    logic [PW:0] sum;
    sum = {1'b0, b} + {1'b0, p};
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign rd_slot = slot_of(base, rd_pos);
  assign wr_slot = slot_of(base, wr_pos);

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_slot];
    end
  end

endmodule

@@ src/bounded_deque_with_erase.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_erase: bounded double-ended queue with erase by key
// Pushes, faults and unused codes: strobe in the cycle after the transfer, busy
// stays low, one item per cycle. Pops: strobe follows one read of the new end
// entry; a pop that empties the queue needs no read and strobes like a push.
// Count and erase: read out one entry per cycle. Results cannot be
// stalled. Synchronous reset empties the queue; store contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_erase
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    operation,
  input  logic [VALUE_W-1:0] value,
  output logic               done,
  output logic [VALUE_W-1:0] popped_value,
  output logic [COUNT_W-1:0] match_count,
  output logic [FAULT_W-1:0] fault,
  output logic [COUNT_W-1:0] occupancy,
  output logic [VALUE_W-1:0] front_value,
  output logic [VALUE_W-1:0] back_value
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RELOAD = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;

  // Control and payload registers.
  logic [1:0]            state, state_next;
  logic [PW-1:0]         front, front_next;
  logic [CW-1:0]         count, count_next;
  logic [DATA_WIDTH-1:0] front_val, front_val_next;
  logic [DATA_WIDTH-1:0] back_val, back_val_next;
  logic [OP_W-1:0]       op_q, op_q_next;
  logic [DATA_WIDTH-1:0] key, key_next;
  logic [CW-1:0]         rpos, rpos_next;
  logic [CW-1:0]         keep_n, keep_n_next;
  logic [CW-1:0]         hits, hits_next;
  logic [DATA_WIDTH-1:0] popped, popped_next;

  // Store port signals.
  logic                  rd_en;
  logic [PW-1:0]         rd_pos;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [PW-1:0]         wr_pos;
  logic [DATA_WIDTH-1:0] wr_data;

  // Result emission.
  logic                  emit;
  logic [DATA_WIDTH-1:0] emit_popped;
  logic [FAULT_W-1:0]    emit_fault;

  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] key_in;
  logic [CW-1:0]         back_pos2;
  logic                  is_match;

  // Value port is taken modulo 2^DATA_WIDTH.
  assign value_ext = 64'(value);
  assign key_in    = value_ext[DATA_WIDTH-1:0];
  assign back_pos2 = count - CW'(2);
  assign busy      = (state != ST_IDLE);
  assign is_match  = (rd_data == key);

  function automatic logic [VALUE_W-1:0] to_port(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    return w[VALUE_W-1:0];
  endfunction

  bdq_ring_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .base    (front),
    .rd_en   (rd_en),
    .rd_pos  (rd_pos),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_pos  (wr_pos),
    .wr_data (wr_data)
  );

  // Operation sequencer: pushes finish at the transfer, pops reload the new
  // end entry, count and erase stream the entries through the read port.
  always_comb begin
    state_next     = state;
    front_next     = front;
    count_next     = count;
    front_val_next = front_val;
    back_val_next  = back_val;
    op_q_next      = op_q;
    key_next       = key;
    rpos_next      = rpos;
    keep_n_next    = keep_n;
    hits_next      = hits;
    popped_next    = popped;
    rd_en          = 1'b0;
    rd_pos         = '0;
    wr_en          = 1'b0;
    wr_pos         = '0;
    wr_data        = key_in;
    emit           = 1'b0;
    emit_popped    = '0;
    emit_fault     = FAULT_NONE;

    case (state)
      ST_IDLE: begin
        if (start) begin
          op_q_next = operation;
          key_next  = key_in;
          hits_next = '0;
          case (operation)
            OP_PUSH_FRONT: begin
              emit = 1'b1;
              if (count == CW'(DEPTH)) begin
                emit_fault = FAULT_OVERFLOW;
              end else begin
                // Position DEPTH-1 from the old front is the slot before it.
                wr_en          = 1'b1;
                wr_pos         = PW'(DEPTH - 1);
                front_next     = (front == '0) ? PW'(DEPTH - 1) : front - PW'(1);
                count_next     = count + CW'(1);
                front_val_next = key_in;
                if (count == '0) begin
                  back_val_next = key_in;
                end
              end
            end
            OP_PUSH_BACK: begin
              emit = 1'b1;
              if (count == CW'(DEPTH)) begin
                emit_fault = FAULT_OVERFLOW;
              end else begin
                wr_en         = 1'b1;
                wr_pos        = count[PW-1:0];
                count_next    = count + CW'(1);
                back_val_next = key_in;
                if (count == '0) begin
                  front_val_next = key_in;
                end
              end
            end
            OP_POP_FRONT: begin
              if (count == '0) begin
                emit       = 1'b1;
                emit_fault = FAULT_UNDERFLOW;
              end else begin
                popped_next = front_val;
                front_next  = (front == PW'(DEPTH - 1)) ? '0 : front + PW'(1);
                count_next  = count - CW'(1);
                if (count == CW'(1)) begin
                  emit        = 1'b1;
                  emit_popped = front_val;
                end else begin
                  rd_en      = 1'b1;
                  rd_pos     = PW'(1);
                  state_next = ST_RELOAD;
                end
              end
            end
            OP_POP_BACK: begin
              if (count == '0) begin
                emit       = 1'b1;
                emit_fault = FAULT_UNDERFLOW;
              end else begin
                popped_next = back_val;
                count_next  = count - CW'(1);
                if (count == CW'(1)) begin
                  emit        = 1'b1;
                  emit_popped = back_val;
                end else begin
                  rd_en      = 1'b1;
                  rd_pos     = back_pos2[PW-1:0];
                  state_next = ST_RELOAD;
                end
              end
            end
            OP_ERASE, OP_COUNT: begin
              if (count == '0) begin
                emit = 1'b1;
                if (operation == OP_ERASE) begin
                  emit_fault = FAULT_UNDERFLOW;
                end
              end else begin
                rd_en       = 1'b1;
                rd_pos      = '0;
                rpos_next   = CW'(1);
                keep_n_next = '0;
                state_next  = ST_SCAN;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_RELOAD: begin
        // The read returns the new end entry after the pop.
        if (op_q == OP_POP_FRONT) begin
          front_val_next = rd_data;
        end else begin
          back_val_next = rd_data;
        end
        emit        = 1'b1;
        emit_popped = popped;
        state_next  = ST_IDLE;
      end

      ST_SCAN: begin
        // Count the entry that just arrived; erase compacts the kept ones.
        if (is_match) begin
          hits_next = hits + CW'(1);
        end else if (op_q == OP_ERASE) begin
          wr_en       = 1'b1;
          wr_pos      = keep_n[PW-1:0];
          wr_data     = rd_data;
          keep_n_next = keep_n + CW'(1);
          back_val_next = rd_data;
          if (keep_n == '0) begin
            front_val_next = rd_data;
          end
        end
        if (rpos < count) begin
          rd_en     = 1'b1;
          rd_pos    = rpos[PW-1:0];
          rpos_next = rpos + CW'(1);
        end else begin
          if (op_q == OP_ERASE) begin
            count_next = keep_n_next;
          end
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      done  <= emit;
    end
  end

  // Payload registers and the result of each transfer.
  always_ff @(posedge clk) begin
    front_val <= front_val_next;
    back_val  <= back_val_next;
    op_q      <= op_q_next;
    key       <= key_next;
    rpos      <= rpos_next;
    keep_n    <= keep_n_next;
    hits      <= hits_next;
    popped    <= popped_next;
    if (emit) begin
      popped_value <= to_port(emit_popped);
      match_count  <= COUNT_W'(hits_next);
      fault        <= emit_fault;
      occupancy    <= COUNT_W'(count_next);
      front_value  <= (count_next == '0) ? '0 : to_port(front_val_next);
      back_value   <= (count_next == '0) ? '0 : to_port(back_val_next);
    end
  end

endmodule
